>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
// Build with ASSERT_OFF defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/cs_pkg.sv
// ----------------------------------------------------------------------------
// cs_pkg
// Types and constants shared by the cosine similarity unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cs_pkg;

    localparam int ELEM_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 14;
    localparam int FIELD_W       = 16;
    localparam int SUM_W         = 48;

    typedef struct packed {
        logic signed [FIELD_W-1:0] elem_a;
        logic signed [FIELD_W-1:0] elem_b;
        logic                      last_elem;
    } cs_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] similarity;
        logic                      zero_norm;
    } cs_result_t;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_CHECK,
        ST_MUL_NAB,
        ST_MUL_D2,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQRT,
        ST_EMIT
    } cs_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CHECK,
        OP_MUL_NAB,
        OP_MUL_D2,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SQRT_STEP,
        OP_EMIT
    } cs_op_t;

    typedef struct packed {
        cs_op_t     op;
        logic [1:0] mul_step;
    } cs_cmd_t;

    typedef struct packed {
        logic last_pend;
        logic zero_norm;
    } cs_status_t;

endpackage

`default_nettype wire

>>> rtl/core/cs_datapath.sv
// ----------------------------------------------------------------------------
// cs_datapath
// Element MAC pipeline, 48-bit sums, split multiplier, restoring divider
// and restoring square root for the final similarity.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cs_datapath #(
    parameter int ELEM_BITS = cs_pkg::ELEM_BITS_DEF,
    parameter int FRAC_BITS = cs_pkg::FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire cs_pkg::cs_item_t  item,
    input  wire cs_pkg::cs_cmd_t   cmd,
    output cs_pkg::cs_status_t     status,
    output cs_pkg::cs_result_t     result,
    output logic                   result_valid
);
    import cs_pkg::*;

    localparam int RW = (ELEM_BITS > FIELD_W) ? ELEM_BITS : FIELD_W;
    localparam int PW = 2 * ELEM_BITS;
    localparam int F  = FRAC_BITS;
    localparam int QW = (F + 2 > FIELD_W) ? F + 2 : FIELD_W;
    localparam int HW = SUM_W / 2;
    localparam int MW = 2 * SUM_W;

    // element decode: sign-extend from the low ELEM_BITS
    logic [RW-1:0]               raw_a, raw_b;
    logic signed [ELEM_BITS-1:0] ea, eb;
    logic signed [PW-1:0]        prod_d, prod_a, prod_b;

    assign raw_a  = RW'($unsigned(item.elem_a));
    assign raw_b  = RW'($unsigned(item.elem_b));
    assign ea     = $signed(raw_a[ELEM_BITS-1:0]);
    assign eb     = $signed(raw_b[ELEM_BITS-1:0]);
    assign prod_d = ea * eb;
    assign prod_a = ea * ea;
    assign prod_b = eb * eb;

    // product stage
    logic                 p1_valid_reg, p1_last_reg;
    logic signed [PW-1:0] pd_reg;
    logic [PW-1:0]        pa_reg, pb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p1_last_reg  <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept;
            p1_last_reg  <= accept && item.last_elem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pd_reg <= prod_d;
            pa_reg <= $unsigned(prod_a);
            pb_reg <= $unsigned(prod_b);
        end
    end

    // saturating accumulate
    logic signed [SUM_W-1:0] dot_reg, dot_next;
    logic [SUM_W-1:0]        na_reg, na_next, nb_reg, nb_next;
    logic [SUM_W:0]          na_wide, nb_wide;
    logic signed [SUM_W:0]   dot_wide;

    always_comb
    begin
        na_wide  = {1'b0, na_reg} + (SUM_W+1)'(pa_reg);
        nb_wide  = {1'b0, nb_reg} + (SUM_W+1)'(pb_reg);
        dot_wide = $signed({dot_reg[SUM_W-1], dot_reg}) + (SUM_W+1)'(pd_reg);
        na_next  = na_reg;
        nb_next  = nb_reg;
        dot_next = dot_reg;
        if (cmd.op == OP_EMIT)
        begin
            na_next  = '0;
            nb_next  = '0;
            dot_next = '0;
        end
        else if (p1_valid_reg)
        begin
            na_next = na_wide[SUM_W] ? '1 : na_wide[SUM_W-1:0];
            nb_next = nb_wide[SUM_W] ? '1 : nb_wide[SUM_W-1:0];
            if (dot_wide[SUM_W] != dot_wide[SUM_W-1])
                dot_next = dot_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                           : {1'b0, {(SUM_W-1){1'b1}}};
            else
                dot_next = dot_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            na_reg  <= '0;
            nb_reg  <= '0;
            dot_reg <= '0;
        end
        else
        begin
            na_reg  <= na_next;
            nb_reg  <= nb_next;
            dot_reg <= dot_next;
        end
    end

    assign status.last_pend = p1_valid_reg && p1_last_reg;
    assign status.zero_norm = (na_reg == '0) || (nb_reg == '0);

    // 48x48 multiply as four 24x24 partial products
    logic [SUM_W-1:0] dmag, mx, my;
    logic [HW-1:0]    xh, yh;
    logic [SUM_W-1:0] pp;
    logic [MW-1:0]    pp_sh, acc_in, acc_sum;
    logic [MW-1:0]    nab_reg;
    logic [MW:0]      rem_reg;

    assign dmag = dot_reg[SUM_W-1] ? $unsigned(-dot_reg) : $unsigned(dot_reg);

    always_comb
    begin
        mx = (cmd.op == OP_MUL_NAB) ? na_reg : dmag;
        my = (cmd.op == OP_MUL_NAB) ? nb_reg : dmag;
        xh = cmd.mul_step[1] ? mx[SUM_W-1:HW] : mx[HW-1:0];
        yh = cmd.mul_step[0] ? my[SUM_W-1:HW] : my[HW-1:0];
        pp = xh * yh;
        case (cmd.mul_step)
            2'b00:   pp_sh = MW'(pp);
            2'b11:   pp_sh = MW'(pp) << (2 * HW);
            default: pp_sh = MW'(pp) << HW;
        endcase
        if (cmd.mul_step == 2'b00)
            acc_in = '0;
        else if (cmd.op == OP_MUL_NAB)
            acc_in = nab_reg;
        else
            acc_in = rem_reg[MW-1:0];
        acc_sum = acc_in + pp_sh;
    end

    // divide and root registers
    logic [MW+1:0]  rem2;
    logic           rem_ge;
    logic [2*F-1:0] quo_reg;
    logic [F-1:0]   root_reg;
    logic [F+2:0]   srem_reg, sr, trial;
    logic           ovf_reg, zero_reg, neg_reg;
    logic [F:0]     qmag;
    logic signed [QW-1:0] qs, sim;

    always_comb
    begin
        rem2   = {rem_reg, 1'b0};
        rem_ge = rem2 >= {2'b00, nab_reg};
        sr     = {srem_reg[F:0], quo_reg[2*F-1 -: 2]};
        trial  = (F+3)'({root_reg, 2'b01});
        qmag   = ovf_reg ? {1'b1, {F{1'b0}}} : {1'b0, root_reg};
        qs     = QW'(qmag);
        sim    = neg_reg ? -qs : qs;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CHECK:
            begin
                zero_reg <= status.zero_norm;
                neg_reg  <= dot_reg[SUM_W-1];
                ovf_reg  <= 1'b0;
            end
            OP_MUL_NAB:
                nab_reg <= acc_sum;
            OP_MUL_D2:
                rem_reg <= {1'b0, acc_sum};
            OP_DIV_INIT:
            begin
                ovf_reg  <= rem_reg >= {1'b0, nab_reg};
                srem_reg <= '0;
                root_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= rem_ge ? (MW+1)'(rem2 - {2'b00, nab_reg}) : rem2[MW:0];
                quo_reg <= {quo_reg[2*F-2:0], rem_ge};
            end
            OP_SQRT_STEP:
            begin
                if (sr >= trial)
                begin
                    srem_reg <= sr - trial;
                    root_reg <= {root_reg[F-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= sr;
                    root_reg <= {root_reg[F-2:0], 1'b0};
                end
                quo_reg <= {quo_reg[2*F-3:0], 2'b00};
            end
            default:
            begin
            end
        endcase
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= (cmd.op == OP_EMIT);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT)
        begin
            result.zero_norm  <= zero_reg;
            result.similarity <= zero_reg ? '0 : sim[FIELD_W-1:0];
        end
    end

    `ASSERT_NEXT(a_emit_clears, clk, rst_n, cmd.op == OP_EMIT,
        na_reg == '0 && nb_reg == '0 && dot_reg == '0)
    `ASSERT_NEXT(a_valid_one_beat, clk, rst_n, result_valid, !result_valid)
    `ASSERT_IMPLIES(a_zero_result, clk, rst_n, result_valid && result.zero_norm,
        result.similarity == '0)

endmodule

`default_nettype wire

>>> rtl/core/cs_controller.sv
// ----------------------------------------------------------------------------
// cs_controller
// Sequencer for the finish phase: zero check, norm product, squared dot, long
// division and square root, then one result beat (a zero norm goes straight to it).
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cs_controller #(
    parameter int FRAC_BITS = cs_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cs_pkg::cs_status_t status,
    output cs_pkg::cs_cmd_t         cmd,
    output logic                    busy
);
    import cs_pkg::*;

    localparam int CW = $clog2(2 * FRAC_BITS + 1);
    localparam logic [CW-1:0] MUL_LAST  = CW'(3);
    localparam logic [CW-1:0] DIV_LAST  = CW'(2 * FRAC_BITS - 1);
    localparam logic [CW-1:0] SQRT_LAST = CW'(FRAC_BITS - 1);

    cs_state_t     state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.op       = OP_NONE;
        cmd.mul_step = cnt_reg[1:0];
        busy         = 1'b1;
        unique case (state_reg)
            ST_ACC:
            begin
                busy     = status.last_pend;
                cnt_next = '0;
                if (status.last_pend)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.op     = OP_CHECK;
                state_next = status.zero_norm ? ST_EMIT : ST_MUL_NAB;
            end
            ST_MUL_NAB:
            begin
                cmd.op   = OP_MUL_NAB;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_MUL_D2;
                end
            end
            ST_MUL_D2:
            begin
                cmd.op   = OP_MUL_D2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.op     = OP_EMIT;
                state_next = ST_ACC;
            end
            default:
                state_next = ST_ACC;
        endcase
    end

    `ASSERT_NEXT(a_emit_to_acc, clk, rst_n, state_reg == ST_EMIT, state_reg == ST_ACC)
    `ASSERT_IMPLIES(a_busy_finish, clk, rst_n, state_reg != ST_ACC, busy)
    `ASSERT_NEXT(a_last_starts, clk, rst_n,
        state_reg == ST_ACC && status.last_pend, state_reg == ST_CHECK)

endmodule

`default_nettype wire

>>> rtl/core/cosine_similarity_unit.sv
// ----------------------------------------------------------------------------
// cosine_similarity_unit
// Streams element pairs, then returns dot / (|a| * |b|) in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: item (elem_a, elem_b, last_elem) is taken on a rising edge
//   with start high and busy low. Pairs may follow every cycle; the three
//   48-bit sums (dot, |a|^2, |b|^2) saturate instead of wrapping.
//   On the pair marked last_elem the unit raises busy and runs its finish
//   sequence: zero check, norm product, squared dot, divide setup, long
//   division to 2*FRAC_BITS quotient bits, square root to FRAC_BITS bits
//   and emit. When a norm is zero, the zero check goes straight to emit.
//   Result beat: result is valid for exactly one cycle with result_valid;
//   the receiver cannot stall it. busy drops in that same cycle, so the
//   next vector may start while the result is shown.
//   zero_norm set means a norm was zero and similarity is 0.
//   Reset clears the sums and returns the sequencer to accumulation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cosine_similarity_unit #(
    parameter int ELEM_BITS = cs_pkg::ELEM_BITS_DEF,
    parameter int FRAC_BITS = cs_pkg::FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire cs_pkg::cs_item_t  item,
    output logic                   busy,
    output cs_pkg::cs_result_t     result,
    output logic                   result_valid
);
    import cs_pkg::*;

    cs_cmd_t    cmd;
    cs_status_t status;
    logic       accept;

    assign accept = start && !busy;

    cs_controller #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    cs_datapath #(
        .ELEM_BITS(ELEM_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

    `ASSERT_NEXT(a_last_sets_busy, clk, rst_n, accept && item.last_elem, busy)
    `ASSERT_IMPLIES(a_result_after_busy, clk, rst_n, result_valid, $past(busy))
    `ASSERT_NEXT(a_single_result, clk, rst_n, result_valid, !result_valid)

endmodule

`default_nettype wire

>>> tb/cosine_similarity_checker.sv
// ----------------------------------------------------------------------------
// cosine_similarity_checker
// Watches the element and result beats of the cosine similarity unit,
// keeps its own running sums, predicts each similarity and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_similarity_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire cs_pkg::cs_item_t  item,
    input  wire cs_pkg::cs_result_t result,
    input  wire logic              result_valid,
    output int                     fail_count,
    output int                     pending,
    output int                     vectors_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import cs_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam logic [47:0]        NORM_SAT = {48{1'b1}};
    localparam logic signed [47:0] DOT_HI   = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] DOT_LO   = {1'b1, {47{1'b0}}};

    logic signed [47:0] acc_dot;
    logic [47:0]        acc_na;
    logic [47:0]        acc_nb;
    cs_result_t         sim_q[$];

    // Largest q <= 2^FRAC with q^2 * na * nb <= (|dot| * 2^FRAC)^2
    function automatic logic signed [15:0] cosine_of(logic signed [47:0] d,
                                                     logic [47:0] na,
                                                     logic [47:0] nb);
        logic [191:0] nab;
        logic [191:0] rhs;
        logic [191:0] lhs;
        logic [47:0]  mag;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  mid;
        mag = d < 0 ? 48'(-d) : 48'(d);
        nab = 192'(na) * 192'(nb);
        rhs = (192'(mag) << FRAC) * (192'(mag) << FRAC);
        lo = 0;
        hi = 32'd1 << FRAC;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            lhs = 192'(mid) * 192'(mid) * nab;
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return d < 0 ? -16'(lo) : 16'(lo);
    endfunction

    // Accumulate on each element beat, predict on the last one
    always @(posedge clk or negedge rst_n)
    begin
        cs_result_t         r;
        logic signed [49:0] dn;
        logic [48:0]        sa;
        logic [48:0]        sb;
        if (!rst_n)
        begin
            acc_dot = '0;
            acc_na = '0;
            acc_nb = '0;
            fail_count = 0;
            pending = 0;
            vectors_seen = 0;
            sim_q.delete();
        end
        else
        begin
            // result beat first: a result may show in the cycle a new beat goes in
            if (result_valid)
            begin
                if (sim_q.size() == 0)
                begin
                    $error("unexpected result similarity=%0d zero_norm=%0b",
                           result.similarity, result.zero_norm);
                    fail_count++;
                end
                else
                begin
                    r = sim_q.pop_front();
                    if (result.similarity !== r.similarity)
                    begin
                        $error("similarity: expected %0d, actual %0d",
                               r.similarity, result.similarity);
                        fail_count++;
                    end
                    if (result.zero_norm !== r.zero_norm)
                    begin
                        $error("zero_norm: expected %0b, actual %0b",
                               r.zero_norm, result.zero_norm);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                sa = 49'(acc_na) + 49'(32'(item.elem_a * item.elem_a));
                sb = 49'(acc_nb) + 49'(32'(item.elem_b * item.elem_b));
                dn = 50'(acc_dot) + 50'(32'(item.elem_a * item.elem_b));
                acc_na = sa[48] ? NORM_SAT : sa[47:0];
                acc_nb = sb[48] ? NORM_SAT : sb[47:0];
                acc_dot = dn > 50'(DOT_HI) ? DOT_HI :
                          dn < 50'(DOT_LO) ? DOT_LO : 48'(dn);
                if (item.last_elem)
                begin
                    if (acc_na == 0 || acc_nb == 0)
                        r = '{similarity: '0, zero_norm: 1'b1};
                    else
                        r = '{similarity: cosine_of(acc_dot, acc_na, acc_nb),
                              zero_norm: 1'b0};
                    sim_q.push_back(r);
                    vectors_seen++;
                    acc_dot = '0;
                    acc_na = '0;
                    acc_nb = '0;
                end
            end
            pending = sim_q.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_cosine_similarity_unit.sv
// ----------------------------------------------------------------------------
// tb_cosine_similarity_unit
// Drives vectors of element pairs into the cosine similarity unit in bursts
// and lets the checker compare every similarity result against prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cosine_similarity_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cs_pkg::*;

    localparam int ITEM_TARGET = 1650;
    localparam int STALL_LIMIT = 2000;

    logic       clk;
    logic       rst_n;
    logic       start;
    cs_item_t   item;
    logic       busy;
    cs_result_t result;
    logic       result_valid;
    int         fail_count;
    int         pending;
    int         vectors_seen;
    int         beats_sent;
    int         idle_cycles;

    cosine_similarity_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid)
    );

    cosine_similarity_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .fail_count   (fail_count),
        .pending      (pending),
        .vectors_seen (vectors_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one pair at the falling edge, hold until taken
    task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic last);
        start <= 1'b1;
        item <= '{elem_a: a, elem_b: b, last_elem: last};
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        beats_sent++;
    endtask

    // Random gap between bursts; sometimes none at all
    task automatic maybe_gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    function automatic logic signed [15:0] rand_elem(input int kind);
        case (kind)
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return 16'($urandom_range(0, 15)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // One random vector of length len, with an optional related second vector
    task automatic send_vector(input int len);
        int                 mode;
        int                 burst;
        logic signed [15:0] a;
        logic signed [15:0] b;
        mode = $urandom_range(0, 5);
        burst = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            a = rand_elem($urandom_range(0, 9));
            case (mode)
                0: b = a;
                1: b = -a;
                2: b = '0;
                3: b = a >>> 2;
                default: b = rand_elem($urandom_range(0, 9));
            endcase
            send_pair(a, b, i == len - 1);
            if (--burst == 0)
            begin
                maybe_gap();
                burst = $urandom_range(1, 8);
            end
        end
    endtask

    initial
    begin
        int len;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        beats_sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero vectors, parallel, antiparallel, orthogonal, extremes
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd5, 16'sd0, 1'b1);
        send_pair(16'sd0, -16'sd7, 1'b1);
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        send_pair(16'sd3, 16'sd4, 1'b0);
        send_pair(16'sd4, -16'sd3, 1'b1);
        send_pair(16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd1, 16'sd2, 1'b0);
        send_pair(-16'sd1, 16'sd3, 1'b1);
        send_pair(16'sh5555, 16'shAAAA, 1'b0);
        send_pair(16'shAAAA, 16'sh5555, 1'b1);
        for (int i = 0; i < 6; i++)
            send_pair(16'sh8000, 16'sh8000, i == 5);

        // Random vectors, mostly short, a few long enough to pile up the sums
        while (beats_sent < ITEM_TARGET)
        begin
            len = $urandom_range(0, 19) == 0 ? $urandom_range(40, 120)
                                             : $urandom_range(1, 12);
            send_vector(len);
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Sent %0d element beats in %0d vectors, including zero norms and full-scale elements.",
                 beats_sent, vectors_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

>>> cosine_similarity_unit.f
+incdir+rtl/core
rtl/core/cs_pkg.sv
rtl/core/cs_datapath.sv
rtl/core/cs_controller.sv
rtl/core/cosine_similarity_unit.sv
tb/cosine_similarity_checker.sv
tb/tb_cosine_similarity_unit.sv
